// File: rtl/core/assert_macros.svh
// assertion macros shared by the rtl of the depth sorter
// both macros sample on clk and are disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/idbs_pkg.sv
// shared types and constants of the isometric depth sorter
// no dependencies
`default_nettype none

package idbs_pkg;

  localparam int DEF_MAX_BLOCKS = 64;
  localparam int DEF_MAX_FRONT  = 16;
  localparam int OUT_LIMIT      = 64;
  localparam int UNIT           = 256;
  localparam int POS_W          = 16;
  localparam int IDX_OUT_W      = 6;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } pos_t;

  typedef enum logic [1:0] {
    REL_NONE,
    REL_P_FRONT,
    REL_Q_FRONT
  } rel_t;

endpackage

`default_nettype wire

// File: rtl/core/idbs_rel.sv
// two-stage pairwise front test of two unit cubes
// depends on idbs_pkg; the differences of p and q are registered, then the result
`default_nettype none

module idbs_rel (
  input  logic          clk,
  input  idbs_pkg::pos_t p,
  input  idbs_pkg::pos_t q,
  output idbs_pkg::rel_t rel
);
  import idbs_pkg::*;

  localparam logic signed [17:0] W2 = 18'(2 * UNIT);
  localparam logic signed [16:0] W1 = 17'(UNIT);

  logic signed [17:0] d_xz_r, d_yz_r, d_xy_r;
  logic signed [16:0] dx_r, dy_r, dz_r;
  rel_t rel_r;
  rel_t rel_c;
  logic scr_ov;

  always_ff @(posedge clk) begin
    d_xz_r <= (18'(p.x) + 18'(p.z)) - (18'(q.x) + 18'(q.z));
    d_yz_r <= (18'(p.y) + 18'(p.z)) - (18'(q.y) + 18'(q.z));
    d_xy_r <= (18'(p.x) - 18'(p.y)) - (18'(q.x) - 18'(q.y));
    dx_r   <= 17'(p.x) - 17'(q.x);
    dy_r   <= 17'(p.y) - 17'(q.y);
    dz_r   <= 17'(p.z) - 17'(q.z);
  end

  always_comb begin
    scr_ov = (d_xz_r < W2) && (d_xz_r > -W2) &&
             (d_yz_r < W2) && (d_yz_r > -W2) &&
             (d_xy_r < W2) && (d_xy_r > -W2);
    rel_c = REL_NONE;
    priority if (!scr_ov) begin
      rel_c = REL_NONE;
    end else if (!((dx_r < W1) && (dx_r > -W1))) begin
      rel_c = (dx_r < 0) ? REL_P_FRONT : REL_Q_FRONT;
    end else if (!((dy_r < W1) && (dy_r > -W1))) begin
      rel_c = (dy_r < 0) ? REL_P_FRONT : REL_Q_FRONT;
    end else if (!((dz_r < W1) && (dz_r > -W1))) begin
      rel_c = (dz_r < 0) ? REL_P_FRONT : REL_Q_FRONT;
    end else begin
      rel_c = REL_NONE;
    end
  end

  always_ff @(posedge clk) begin
    rel_r <= rel_c;
  end

  assign rel = rel_r;

endmodule

`default_nettype wire

// File: rtl/core/isometric_block_depth_sort.sv
// blocks load while in_stall is low. on the final block the sorter clears the per-block
// counts, tests the n(n-1)/2 pairs, queues blocks with none in front, walks the queue
// and shows each result until out_stall lets it go. one set at a time; the memories and
// the shared pair test set the pace. synchronous active-low reset clears
// the sequencer, block count, overflow flag and output valid; memories are not cleared
`default_nettype none

module isometric_block_depth_sort #(
  parameter int MAX_BLOCKS = idbs_pkg::DEF_MAX_BLOCKS,
  parameter int MAX_FRONT  = idbs_pkg::DEF_MAX_FRONT
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [idbs_pkg::POS_W-1:0]    in_pos_x,
  input  logic signed [idbs_pkg::POS_W-1:0]    in_pos_y,
  input  logic signed [idbs_pkg::POS_W-1:0]    in_pos_z,
  input  logic                                 in_final_block,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [idbs_pkg::IDX_OUT_W-1:0]       out_block_index,
  output logic                                 out_entry_valid,
  output logic                                 out_end_of_list,
  output logic                                 out_overflow_seen
);
  import idbs_pkg::*;
  `include "assert_macros.svh"

  localparam int IW  = $clog2(MAX_BLOCKS);
  localparam int CW  = $clog2(MAX_BLOCKS + 1);
  localparam int FCW = $clog2(MAX_FRONT + 1);
  localparam int FLD = MAX_BLOCKS * MAX_FRONT;
  localparam int FAW = $clog2(FLD);
  localparam int OW  = (CW > 7) ? CW : 7;

  typedef enum logic [4:0] {
    S_LOAD, S_CLR, S_PI, S_PIW, S_PJ, S_W1, S_W2, S_DEC, S_FRD, S_FC, S_PC,
    S_KRD, S_KCHK, S_WDQ, S_WA, S_WARD, S_WFC, S_WFL, S_WF, S_WFRD, S_WPC,
    S_ORD, S_OSH, S_OWT
  } state_t;

  state_t state_r;

  pos_t           pos_mem [MAX_BLOCKS];
  logic [IW-1:0]  fl_mem  [FLD];
  logic [FCW-1:0] fc_mem  [MAX_BLOCKS];
  logic [CW-1:0]  pc_mem  [MAX_BLOCKS];
  logic [IW-1:0]  dq_mem  [MAX_BLOCKS];

  pos_t           pos_rd_r;
  logic [IW-1:0]  fl_rd_r;
  logic [FCW-1:0] fc_rd_r;
  logic [CW-1:0]  pc_rd_r;
  logic [IW-1:0]  dq_rd_r;

  logic [CW-1:0]  count_r;
  logic           ovf_r;
  logic [CW-1:0]  k_r;
  logic [IW-1:0]  i_r, j_r, front_r, back_r, a_r, f_r;
  logic [CW-1:0]  qlen_r, h_r;
  logic [OW-1:0]  o_r;
  logic [FCW-1:0] fcnt_r, jj_r;
  logic           pinc_r;
  pos_t           pi_r;
  rel_t           rel;

  logic                out_valid_r, out_entry_valid_r, out_end_of_list_r, out_ovf_r;
  logic [IDX_OUT_W-1:0] out_block_index_r;

  logic           pos_we;
  logic [IW-1:0]  pos_raddr, fc_raddr, pc_raddr, dq_raddr;
  logic [FAW-1:0] fl_raddr, fl_wa;
  logic           fl_we, fc_we, pc_we, dq_we;
  logic [IW-1:0]  fl_wd, fc_wa, pc_wa, dq_wa, dq_wd;
  logic [FCW-1:0] fc_wd;
  logic [CW-1:0]  pc_wd;
  pos_t           in_pos;
  logic           out_last;

  assign in_pos = '{x: in_pos_x, y: in_pos_y, z: in_pos_z};
  assign pos_we = (state_r == S_LOAD) && in_valid && (count_r < CW'(MAX_BLOCKS));
  assign out_last = ((o_r + OW'(1)) == OW'(qlen_r)) || ((o_r + OW'(1)) == OW'(OUT_LIMIT));

  idbs_rel u_rel (
    .clk (clk),
    .p   (pi_r),
    .q   (pos_rd_r),
    .rel (rel)
  );

  always_comb begin
    pos_raddr = (state_r == S_PI) ? i_r : j_r;
    fc_raddr  = (state_r == S_WARD) ? a_r : front_r;
    priority case (state_r)
      S_KRD:   pc_raddr = k_r[IW-1:0];
      S_FC:    pc_raddr = back_r;
      default: pc_raddr = f_r;
    endcase
    dq_raddr = (state_r == S_WDQ) ? h_r[IW-1:0] : o_r[IW-1:0];
    fl_raddr = FAW'(a_r) * FAW'(MAX_FRONT) + FAW'(jj_r);
    fl_we = 1'b0;
    fl_wa = FAW'(front_r) * FAW'(MAX_FRONT) + FAW'(fc_rd_r);
    fl_wd = back_r;
    fc_we = 1'b0;
    fc_wa = front_r;
    fc_wd = fc_rd_r + FCW'(1);
    pc_we = 1'b0;
    pc_wa = back_r;
    pc_wd = pc_rd_r + CW'(1);
    dq_we = 1'b0;
    dq_wa = qlen_r[IW-1:0];
    dq_wd = k_r[IW-1:0];
    unique case (state_r)
      S_CLR: begin
        fc_we = 1'b1;
        fc_wa = k_r[IW-1:0];
        fc_wd = '0;
        pc_we = 1'b1;
        pc_wa = k_r[IW-1:0];
        pc_wd = '0;
      end
      S_FC: begin
        if (fc_rd_r < FCW'(MAX_FRONT)) begin
          fc_we = 1'b1;
          fl_we = 1'b1;
        end
      end
      S_PC: begin
        pc_we = pinc_r;
      end
      S_KCHK: begin
        dq_we = (pc_rd_r == '0);
      end
      S_WPC: begin
        if (pc_rd_r != '0) begin
          pc_we = 1'b1;
          pc_wa = f_r;
          pc_wd = pc_rd_r - CW'(1);
          if ((pc_rd_r == CW'(1)) && (qlen_r < CW'(MAX_BLOCKS))) begin
            dq_we = 1'b1;
            dq_wd = f_r;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[count_r[IW-1:0]] <= in_pos;
    pos_rd_r <= pos_mem[pos_raddr];
  end

  always_ff @(posedge clk) begin
    if (fl_we) fl_mem[fl_wa] <= fl_wd;
    fl_rd_r <= fl_mem[fl_raddr];
  end

  always_ff @(posedge clk) begin
    if (fc_we) fc_mem[fc_wa] <= fc_wd;
    fc_rd_r <= fc_mem[fc_raddr];
  end

  always_ff @(posedge clk) begin
    if (pc_we) pc_mem[pc_wa] <= pc_wd;
    pc_rd_r <= pc_mem[pc_raddr];
  end

  always_ff @(posedge clk) begin
    if (dq_we) dq_mem[dq_wa] <= dq_wd;
    dq_rd_r <= dq_mem[dq_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      qlen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (dq_we) qlen_r <= qlen_r + CW'(1);
      unique case (state_r)
        S_LOAD: begin
          if (in_valid) begin
            if (pos_we) count_r <= count_r + CW'(1);
            else ovf_r <= 1'b1;
            if (in_final_block) begin
              k_r     <= '0;
              state_r <= S_CLR;
            end
          end
        end
        S_CLR: begin
          if ((k_r + CW'(1)) >= count_r) begin
            i_r <= '0;
            j_r <= IW'(1);
            k_r <= '0;
            if (count_r >= CW'(2)) begin
              state_r <= S_PI;
            end else begin
              qlen_r  <= '0;
              state_r <= S_KRD;
            end
          end else begin
            k_r <= k_r + CW'(1);
          end
        end
        S_PI:  state_r <= S_PIW;
        S_PIW: begin
          pi_r    <= pos_rd_r;
          state_r <= S_PJ;
        end
        S_PJ:  state_r <= S_W1;
        S_W1:  state_r <= S_W2;
        S_W2:  state_r <= S_DEC;
        S_DEC: begin
          unique case (rel)
            REL_P_FRONT: begin
              front_r <= i_r;
              back_r  <= j_r;
              state_r <= S_FRD;
            end
            REL_Q_FRONT: begin
              front_r <= j_r;
              back_r  <= i_r;
              state_r <= S_FRD;
            end
            default: begin
              pinc_r  <= 1'b0;
              state_r <= S_PC;
            end
          endcase
        end
        S_FRD: state_r <= S_FC;
        S_FC: begin
          if (fc_rd_r < FCW'(MAX_FRONT)) begin
            pinc_r  <= 1'b1;
            state_r <= S_PC;
          end else begin
            ovf_r   <= 1'b1;
            pinc_r  <= 1'b0;
            state_r <= S_PC;
            front_r <= front_r;
          end
        end
        S_PC: begin
          if ((CW'(j_r) + CW'(1)) < count_r) begin
            j_r     <= j_r + IW'(1);
            state_r <= S_PJ;
          end else if ((CW'(i_r) + CW'(2)) < count_r) begin
            i_r     <= i_r + IW'(1);
            j_r     <= i_r + IW'(2);
            state_r <= S_PI;
          end else begin
            k_r     <= '0;
            qlen_r  <= '0;
            state_r <= S_KRD;
          end
        end
        S_KRD: state_r <= S_KCHK;
        S_KCHK: begin
          k_r <= k_r + CW'(1);
          if ((k_r + CW'(1)) < count_r) begin
            state_r <= S_KRD;
          end else begin
            h_r     <= '0;
            state_r <= S_WDQ;
          end
        end
        S_WDQ: begin
          if (h_r < qlen_r) begin
            state_r <= S_WA;
          end else begin
            o_r     <= '0;
            state_r <= S_ORD;
          end
        end
        S_WA: begin
          a_r     <= dq_rd_r;
          state_r <= S_WARD;
        end
        S_WARD: state_r <= S_WFC;
        S_WFC: begin
          fcnt_r  <= fc_rd_r;
          jj_r    <= '0;
          state_r <= S_WFL;
        end
        S_WFL: begin
          if (jj_r < fcnt_r) begin
            state_r <= S_WF;
          end else begin
            h_r     <= h_r + CW'(1);
            state_r <= S_WDQ;
          end
        end
        S_WF: begin
          f_r     <= fl_rd_r;
          state_r <= S_WFRD;
        end
        S_WFRD: state_r <= S_WPC;
        S_WPC: begin
          jj_r    <= jj_r + FCW'(1);
          state_r <= S_WFL;
        end
        S_ORD: state_r <= S_OSH;
        S_OSH: begin
          out_valid_r <= 1'b1;
          out_ovf_r   <= ovf_r;
          if (qlen_r == '0) begin
            out_block_index_r <= '0;
            out_entry_valid_r <= 1'b0;
            out_end_of_list_r <= 1'b1;
          end else begin
            out_block_index_r <= IDX_OUT_W'(dq_rd_r);
            out_entry_valid_r <= 1'b1;
            out_end_of_list_r <= out_last;
          end
          state_r <= S_OWT;
        end
        S_OWT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            if (out_end_of_list_r) begin
              count_r <= '0;
              ovf_r   <= 1'b0;
              qlen_r  <= '0;
              state_r <= S_LOAD;
            end else begin
              o_r     <= o_r + OW'(1);
              state_r <= S_ORD;
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  assign in_stall          = (state_r != S_LOAD);
  assign out_valid         = out_valid_r;
  assign out_block_index   = out_block_index_r;
  assign out_entry_valid   = out_entry_valid_r;
  assign out_end_of_list   = out_end_of_list_r;
  assign out_overflow_seen = out_ovf_r;

  `ASSERT_ALWAYS(a_busy_while_out, !out_valid || in_stall, "result shown while loading")
  `ASSERT_ALWAYS(a_count_max, count_r <= CW'(MAX_BLOCKS), "block count past capacity")
  `ASSERT_ALWAYS(a_qlen_count, qlen_r <= count_r, "queue longer than block set")
  `ASSERT_NEXT(a_eol_ret, out_valid && !out_stall && out_end_of_list, !in_stall && !out_valid, "no return to load after last item")

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// self-checking testbench for isometric_block_depth_sort: block sets in, draw order out
// a built-in depth-order predictor checks every result item; depends on idbs_pkg and the rtl
`timescale 1ns / 1ps

module tb_top;
  import idbs_pkg::*;

  localparam int NBLK = DEF_MAX_BLOCKS;
  localparam int NFRONT = DEF_MAX_FRONT;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic fin;
  } blk_item_t;

  typedef struct {
    logic [5:0] idx;
    logic ev;
    logic eol;
    logic ovf;
  } draw_item_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [15:0] in_pos_x, in_pos_y, in_pos_z;
  logic in_final_block;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [5:0] out_block_index;
  logic out_entry_valid, out_end_of_list, out_overflow_seen;

  isometric_block_depth_sort i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_pos_z(in_pos_z),
    .in_final_block(in_final_block),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_block_index(out_block_index), .out_entry_valid(out_entry_valid),
    .out_end_of_list(out_end_of_list), .out_overflow_seen(out_overflow_seen)
  );

  // predictor state
  int signed set_pos [NBLK][3];
  int set_count;
  bit set_ovf;
  draw_item_t expected_draws[$];
  blk_item_t blk_plan[$];
  draw_item_t fixed_draws[$];
  int mismatches = 0;
  bit long_hold;
  bit no_idle;

  function automatic bit spans_apart(int signed a, int signed b, int signed w);
    return !((a + w > b) && (b + w > a));
  endfunction

  function automatic rel_t pair_rel(int i, int j);
    int signed p[3], q[3];
    for (int k = 0; k < 3; k++) begin
      p[k] = set_pos[i][k];
      q[k] = set_pos[j][k];
    end
    if (spans_apart(p[0] + p[2], q[0] + q[2], 2 * UNIT)) return REL_NONE;
    if (spans_apart(p[1] + p[2], q[1] + q[2], 2 * UNIT)) return REL_NONE;
    if (spans_apart(p[0] - p[1], q[0] - q[1], 2 * UNIT)) return REL_NONE;
    for (int k = 0; k < 3; k++)
      if (spans_apart(p[k], q[k], UNIT)) return (p[k] < q[k]) ? REL_P_FRONT : REL_Q_FRONT;
    return REL_NONE;
  endfunction

  task automatic sort_block(blk_item_t b);
    int fcnt[NBLK], pend[NBLK], flist[NBLK][NFRONT], order[$];
    int n, fr, bk, a, f, nout;
    rel_t r;
    draw_item_t d;
    if (set_count < NBLK) begin
      set_pos[set_count][0] = int'(b.x);
      set_pos[set_count][1] = int'(b.y);
      set_pos[set_count][2] = int'(b.z);
      set_count++;
    end else set_ovf = 1;
    if (!b.fin) return;
    n = set_count;
    for (int i = 0; i < n; i++) begin
      fcnt[i] = 0;
      pend[i] = 0;
    end
    for (int i = 0; i < n; i++)
      for (int j = i + 1; j < n; j++) begin
        r = pair_rel(i, j);
        if (r != REL_NONE) begin
          fr = (r == REL_P_FRONT) ? i : j;
          bk = (r == REL_P_FRONT) ? j : i;
          if (fcnt[fr] >= NFRONT) set_ovf = 1;
          else begin
            flist[fr][fcnt[fr]] = bk;
            fcnt[fr]++;
            pend[bk]++;
          end
        end
      end
    for (int i = 0; i < n; i++) if (pend[i] == 0) order.push_back(i);
    for (int i = 0; i < order.size(); i++) begin
      a = order[i];
      for (int j = 0; j < fcnt[a]; j++) begin
        f = flist[a][j];
        if (pend[f] != 0) begin
          pend[f]--;
          if (pend[f] == 0 && order.size() < NBLK) order.push_back(f);
        end
      end
    end
    if (order.size() == 0) begin
      d.idx = 0; d.ev = 0; d.eol = 1; d.ovf = set_ovf;
      expected_draws.push_back(d);
    end else begin
      nout = (order.size() < OUT_LIMIT) ? order.size() : OUT_LIMIT;
      for (int i = 0; i < nout; i++) begin
        d.idx = order[i][5:0]; d.ev = 1; d.eol = (i + 1 == nout); d.ovf = set_ovf;
        expected_draws.push_back(d);
      end
    end
    set_count = 0;
    set_ovf = 0;
  endtask

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #50000000;
    $display("isometric_block_depth_sort verification failed");
    $finish;
  end

  // result side: stall bursts, long hold, compare
  int hold_left = 0;

  always @(posedge clk) begin
    draw_item_t e;
    draw_item_t t;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_draws.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item idx=%0d", out_block_index);
      end else begin
        e = expected_draws.pop_front();
        if (e.idx !== out_block_index || e.ev !== out_entry_valid ||
            e.eol !== out_end_of_list || e.ovf !== out_overflow_seen) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp idx=%0d ev=%0b eol=%0b ovf=%0b got %0d %0b %0b %0b",
                     e.idx, e.ev, e.eol, e.ovf, out_block_index, out_entry_valid,
                     out_end_of_list, out_overflow_seen);
        end
      end
      // typed rows come first in the result stream
      if (fixed_draws.size() != 0) begin
        t = fixed_draws.pop_front();
        if (t.idx !== out_block_index || t.ev !== out_entry_valid ||
            t.eol !== out_end_of_list || t.ovf !== out_overflow_seen) begin
          mismatches++;
          if (mismatches <= 10)
            $display("typed mismatch exp idx=%0d ev=%0b eol=%0b ovf=%0b got %0d %0b %0b %0b",
                     t.idx, t.ev, t.eol, t.ovf, out_block_index, out_entry_valid,
                     out_end_of_list, out_overflow_seen);
        end
      end
    end
    if (long_hold) out_stall <= 1'b1;
    else if (no_idle) out_stall <= 1'b0;
    else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 9) == 0) begin
      hold_left <= $urandom_range(0, 7);
      out_stall <= 1'b1;
    end else out_stall <= 1'b0;
  end

  function automatic blk_item_t mk(int x, int y, int z, bit fin);
    blk_item_t b;
    b.x = 16'(x); b.y = 16'(y); b.z = 16'(z); b.fin = fin;
    return b;
  endfunction

  function automatic draw_item_t dr(int idx, bit ev, bit eol, bit ovf);
    draw_item_t d;
    d.idx = 6'(idx); d.ev = ev; d.eol = eol; d.ovf = ovf;
    return d;
  endfunction

  task automatic send_block(blk_item_t b);
    in_pos_x <= b.x;
    in_pos_y <= b.y;
    in_pos_z <= b.z;
    in_final_block <= b.fin;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sort_block(b);
  endtask

  task automatic idle_gap();
    int g;
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      g = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_draws.size() != 0);
  endtask

  function automatic int rnd_coord(int near);
    case ($urandom_range(0, 9))
      0: return $signed(16'($urandom()));
      1: return $urandom_range(0, 1) ? 32767 : -32768;
      default: return near + $signed(11'($urandom()));
    endcase
  endfunction

  task automatic rand_set(int nb);
    int base;
    blk_item_t b;
    base = $signed(16'($urandom())) / 2;
    for (int i = 0; i < nb; i++) begin
      b = mk(rnd_coord(base), rnd_coord(base), rnd_coord(base), i == nb - 1);
      send_block(b);
      idle_gap();
    end
  endtask

  initial begin
    int sent;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_pos_x = '0;
    in_pos_y = '0;
    in_pos_z = '0;
    in_final_block = 1'b0;
    long_hold = 0;
    no_idle = 0;
    set_count = 0;
    set_ovf = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table; rows with typed results are checked against them too
    blk_plan = '{
      mk(0, 0, 0, 1),
      mk(0, 0, 0, 0), mk(0, 0, 0, 1),
      mk(0, 0, 0, 0), mk(256, 0, 0, 1),
      mk(256, 0, 0, 0), mk(0, 0, 0, 1),
      mk(0, 0, 0, 0), mk(0, 0, 256, 1),
      mk(0, 0, 0, 0), mk(0, 256, 0, 1),
      mk(32767, 32767, 32767, 0), mk(-32768, -32768, -32768, 1),
      mk(0, 0, 0, 0), mk(255, 0, 0, 0), mk(0, 0, 512, 1),
      mk(0, 0, 0, 0), mk(256, 0, 0, 0), mk(0, 256, 0, 1)
    };
    fixed_draws = '{
      dr(0, 1, 1, 0),
      dr(0, 1, 0, 0), dr(1, 1, 1, 0),
      dr(0, 1, 0, 0), dr(1, 1, 1, 0),
      dr(1, 1, 0, 0), dr(0, 1, 1, 0),
      dr(0, 1, 0, 0), dr(1, 1, 1, 0)
    };
    foreach (blk_plan[i]) begin
      send_block(blk_plan[i]);
      idle_gap();
    end
    drain();

    // three blocks: block 0 lies in front of both others, which do not overlap
    send_block(mk(0, 0, 0, 0));
    send_block(mk(256, -200, 100, 0));
    send_block(mk(-100, 256, 200, 1));
    // overflow: 66 blocks in one cluster
    for (int i = 0; i < 66; i++) send_block(mk(i * 8, i * 4, (i % 3) * 300, i == 65));
    // long receiver hold while the sender keeps going
    long_hold = 1;
    fork
      begin
        rand_set(4);
        rand_set(6);
      end
      begin
        repeat (3000) @(posedge clk);
        long_hold = 0;
      end
    join
    drain();

    sent = 0;
    while (sent < 180) begin
      int nb;
      nb = $urandom_range(0, 7) == 0 ? $urandom_range(20, 66) : $urandom_range(1, 8);
      if (sent > 140) no_idle = 1;
      rand_set(nb);
      sent += nb;
      if ($urandom_range(0, 4) == 0) drain();
    end
    drain();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_draws.size() == 0)
      $display("isometric_block_depth_sort verification clean");
    else
      $display("isometric_block_depth_sort verification failed");
    $finish;
  end
endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/idbs_pkg.sv
rtl/core/idbs_rel.sv
rtl/core/isometric_block_depth_sort.sv
tb/sv/tb_top.sv
